// ===== src/tspe_pkg.sv =====
// shared constants for the tour evaluator
package tspe_pkg;

    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_BITS_DEF  = 32;

    localparam int CMD_W       = 2;
    localparam int CITY_W      = 4;
    localparam int DIST_W      = 32;
    localparam int CNT_W       = 5;
    localparam int COST_W      = 36;
    localparam int MIN_CITIES  = 3;

    localparam logic [CNT_W-1:0]  NUM_CITIES_RESET = 5'd4;
    localparam logic [COST_W-1:0] COST_MAX         = '1;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

endpackage

// ===== src/tspe_tour_mem.sv =====
// tour order memory, unwritten or cleared entries read as their own index
module tspe_tour_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [AW-1:0]    mem_q_reg;
    logic [AW-1:0]    addr_q_reg;
    logic             valid_q_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg   <= mem[raddr];
        addr_q_reg  <= raddr;
        valid_q_reg <= valid_reg[raddr];
    end

    assign rdata = valid_q_reg ? mem_q_reg : addr_q_reg;

endmodule

// ===== src/tspe_dist_mem.sv =====
// distance matrix memory, one write and one registered read per cycle
module tspe_dist_mem #(
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  logic            clk,
    input  logic            we,
    input  logic [2*AW-1:0] waddr,
    input  logic [DW-1:0]   wdata,
    input  logic [2*AW-1:0] raddr,
    output logic [DW-1:0]   rdata
);

    localparam int DEPTH = 1 << (2 * AW);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tsp_permutation_tour_evaluator_core.sv =====
// Brute-force tour evaluator: enumerates closed tours with city 0 fixed and scores each
// against a loaded distance matrix. A load transaction writes the distance memory as it is
// taken and leaves the block idle for the next item. A restart or a step holds off new
// items until its result has been placed on the output, and a step takes longer the longer
// the reordered tail is. All of it is paced by the single read port of the tour memory,
// which serves the pivot scan, the tail reversal and the n reads of the scoring pass,
// followed by n matrix reads in the distance memory.
module tsp_permutation_tour_evaluator_core
    import tspe_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [CITY_W-1:0] from_city,
    input  logic [CITY_W-1:0] to_city,
    input  logic [DIST_W-1:0] distance,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [COST_W-1:0] tour_cost,
    output logic [COST_W-1:0] best_cost,
    output logic              last_permutation
);

    localparam int AW    = $clog2(MAX_CITIES);
    localparam int NW    = $clog2(MAX_CITIES + 1);
    localparam int SUM_W = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PFIRST = 4'd1;
    localparam logic [3:0] ST_PSCAN = 4'd2;
    localparam logic [3:0] ST_RDQ   = 4'd3;
    localparam logic [3:0] ST_WRP   = 4'd4;
    localparam logic [3:0] ST_WRQ   = 4'd5;
    localparam logic [3:0] ST_FIXB  = 4'd6;
    localparam logic [3:0] ST_FIXM  = 4'd7;
    localparam logic [3:0] ST_SCORE = 4'd8;
    localparam logic [3:0] ST_DRAIN = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  num_cities_reg;
    logic [NW-1:0]     n_eff;
    logic [AW-1:0]     last_idx;

    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     m_reg, m_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [AW-1:0]     q_reg, q_next;
    logic [AW-1:0]     prev_reg, prev_next;
    logic [AW-1:0]     pv_reg, pv_next;
    logic [AW-1:0]     vp_reg, vp_next;
    logic [AW-1:0]     best_reg, best_next;
    logic [AW-1:0]     bpos_reg, bpos_next;
    logic              best_found_reg, best_found_next;
    logic              wrap_reg, wrap_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     first_reg, first_next;

    logic              tr_v_reg, tr_v_next;
    logic              tr_first_reg, tr_first_next;
    logic              tr_last_reg, tr_last_next;
    logic              close_reg, close_next;
    logic              dr_v_reg, dr_v_next;
    logic              dr_last_reg, dr_last_next;

    logic [COST_W-1:0] acc_reg, acc_next;
    logic [COST_W-1:0] lowest_reg, lowest_next;
    logic [SUM_W-1:0]  acc_sum;
    logic [COST_W-1:0] new_lowest;

    logic              result_valid_reg, result_valid_next;
    logic [COST_W-1:0] tour_cost_reg, tour_cost_next;
    logic [COST_W-1:0] best_cost_reg, best_cost_next;
    logic              last_perm_reg, last_perm_next;

    logic              cons_en;
    logic [AW-1:0]     cons_v;
    logic [AW-1:0]     cons_pos;

    logic              tour_clear;
    logic              tour_we;
    logic [AW-1:0]     tour_waddr;
    logic [AW-1:0]     tour_wdata;
    logic [AW-1:0]     tour_raddr;
    logic [AW-1:0]     tour_rdata;

    logic                 dist_we;
    logic [2*AW-1:0]      dist_waddr;
    logic [DIST_BITS-1:0] dist_wdata;
    logic [2*AW-1:0]      dist_raddr;
    logic [DIST_BITS-1:0] dist_rdata;
    logic [DIST_BITS+DIST_W-1:0] dist_ext;

    logic accept_item;
    logic load_in_range;

    tspe_tour_mem #(
        .DEPTH (MAX_CITIES),
        .AW    (AW)
    ) u_tour_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (tour_clear),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    tspe_dist_mem #(
        .AW (AW),
        .DW (DIST_BITS)
    ) u_dist_mem (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // effective city count, clamped to the supported range
    always_comb
    begin
        if (num_cities_reg < CNT_W'(MIN_CITIES))
        begin
            n_eff = NW'(MIN_CITIES);
        end
        else if (32'(num_cities_reg) > MAX_CITIES)
        begin
            n_eff = NW'(MAX_CITIES);
        end
        else
        begin
            n_eff = NW'(num_cities_reg);
        end
    end

    assign last_idx      = AW'(n_eff - NW'(1));
    assign item_stall    = (state_reg != ST_IDLE);
    assign accept_item   = item_valid && !item_stall;
    assign load_in_range = (32'(from_city) < MAX_CITIES) && (32'(to_city) < MAX_CITIES);
    assign dist_ext      = {{DIST_BITS{1'b0}}, distance};
    assign dist_wdata    = dist_ext[DIST_BITS-1:0];
    assign dist_waddr    = {AW'(from_city), AW'(to_city)};
    assign acc_sum       = SUM_W'(acc_reg) + SUM_W'(dist_rdata);
    assign new_lowest    = (acc_reg < lowest_reg) ? acc_reg : lowest_reg;

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        m_next            = m_reg;
        p_next            = p_reg;
        q_next            = q_reg;
        prev_next         = prev_reg;
        pv_next           = pv_reg;
        vp_next           = vp_reg;
        best_next         = best_reg;
        bpos_next         = bpos_reg;
        best_found_next   = best_found_reg;
        wrap_next         = wrap_reg;
        idx_next          = idx_reg;
        first_next        = first_reg;
        tr_v_next         = 1'b0;
        tr_first_next     = 1'b0;
        tr_last_next      = 1'b0;
        close_next        = 1'b0;
        dr_v_next         = 1'b0;
        dr_last_next      = 1'b0;
        acc_next          = acc_reg;
        lowest_next       = lowest_reg;
        result_valid_next = result_valid_reg && result_stall;
        tour_cost_next    = tour_cost_reg;
        best_cost_next    = best_cost_reg;
        last_perm_next    = last_perm_reg;
        cons_en           = 1'b0;
        cons_v            = '0;
        cons_pos          = '0;
        tour_clear        = 1'b0;
        tour_we           = 1'b0;
        tour_waddr        = '0;
        tour_wdata        = '0;
        tour_raddr        = '0;
        dist_we           = 1'b0;
        dist_raddr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_item)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            dist_we = load_in_range;
                        end
                        CMD_RESTART:
                        begin
                            tour_clear  = 1'b1;
                            lowest_next = COST_MAX;
                            wrap_next   = 1'b0;
                            idx_next    = '0;
                            acc_next    = '0;
                            state_next  = ST_SCORE;
                        end
                        CMD_STEP:
                        begin
                            tour_raddr = last_idx;
                            ptr_next   = last_idx - AW'(1);
                            wrap_next  = 1'b0;
                            state_next = ST_PFIRST;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PFIRST:
            begin
                prev_next  = tour_rdata;
                tour_raddr = ptr_reg;
                state_next = ST_PSCAN;
            end
            ST_PSCAN:
            begin
                if (tour_rdata > prev_reg)
                begin
                    if (ptr_reg == AW'(1))
                    begin
                        // last ordering, back to identity
                        tour_clear = 1'b1;
                        wrap_next  = 1'b1;
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = ST_SCORE;
                    end
                    else
                    begin
                        prev_next  = tour_rdata;
                        ptr_next   = ptr_reg - AW'(1);
                        tour_raddr = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    m_next          = ptr_reg;
                    pv_next         = tour_rdata;
                    p_next          = ptr_reg + AW'(1);
                    q_next          = last_idx;
                    best_found_next = 1'b0;
                    tour_raddr      = ptr_reg + AW'(1);
                    state_next      = ST_RDQ;
                end
            end
            ST_RDQ:
            begin
                vp_next = tour_rdata;
                if (p_reg == q_reg)
                begin
                    cons_en    = 1'b1;
                    cons_v     = tour_rdata;
                    cons_pos   = p_reg;
                    state_next = ST_FIXB;
                end
                else
                begin
                    tour_raddr = q_reg;
                    state_next = ST_WRP;
                end
            end
            ST_WRP:
            begin
                tour_we    = 1'b1;
                tour_waddr = p_reg;
                tour_wdata = tour_rdata;
                cons_en    = 1'b1;
                cons_v     = tour_rdata;
                cons_pos   = p_reg;
                state_next = ST_WRQ;
            end
            ST_WRQ:
            begin
                tour_we    = 1'b1;
                tour_waddr = q_reg;
                tour_wdata = vp_reg;
                cons_en    = 1'b1;
                cons_v     = vp_reg;
                cons_pos   = q_reg;
                p_next     = p_reg + AW'(1);
                q_next     = q_reg - AW'(1);
                if ((p_reg + AW'(1)) <= (q_reg - AW'(1)))
                begin
                    tour_raddr = p_reg + AW'(1);
                    state_next = ST_RDQ;
                end
                else
                begin
                    state_next = ST_FIXB;
                end
            end
            ST_FIXB:
            begin
                // pivot takes the place of its successor in the reversed tail
                tour_we    = 1'b1;
                tour_waddr = bpos_reg;
                tour_wdata = pv_reg;
                state_next = ST_FIXM;
            end
            ST_FIXM:
            begin
                tour_we    = 1'b1;
                tour_waddr = m_reg;
                tour_wdata = best_reg;
                idx_next   = '0;
                acc_next   = '0;
                state_next = ST_SCORE;
            end
            ST_SCORE:
            begin
                tour_raddr    = idx_reg;
                tr_v_next     = 1'b1;
                tr_first_next = (idx_reg == '0);
                tr_last_next  = (idx_reg == last_idx);
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (dr_v_reg && dr_last_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    tour_cost_next    = acc_reg;
                    best_cost_next    = new_lowest;
                    lowest_next       = new_lowest;
                    last_perm_next    = wrap_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // successor of the pivot: smallest tail value above it
        if (cons_en && (cons_v > pv_reg) && (!best_found_reg || (cons_v < best_reg)))
        begin
            best_next       = cons_v;
            bpos_next       = cons_pos;
            best_found_next = 1'b1;
        end

        // scoring pipeline: tour read, matrix read, accumulate
        if (tr_v_reg)
        begin
            if (tr_first_reg)
            begin
                first_next = tour_rdata;
            end
            else
            begin
                dist_raddr = {prev_reg, tour_rdata};
                dr_v_next  = 1'b1;
            end
            prev_next = tour_rdata;
            if (tr_last_reg)
            begin
                close_next = 1'b1;
            end
        end

        if (close_reg)
        begin
            dist_raddr   = {prev_reg, first_reg};
            dr_v_next    = 1'b1;
            dr_last_next = 1'b1;
        end

        if (dr_v_reg)
        begin
            acc_next = (acc_sum > SUM_W'(COST_MAX)) ? COST_MAX : acc_sum[COST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            num_cities_reg   <= NUM_CITIES_RESET;
            lowest_reg       <= COST_MAX;
            wrap_reg         <= 1'b0;
            best_found_reg   <= 1'b0;
            tr_v_reg         <= 1'b0;
            tr_first_reg     <= 1'b0;
            tr_last_reg      <= 1'b0;
            close_reg        <= 1'b0;
            dr_v_reg         <= 1'b0;
            dr_last_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                num_cities_reg <= cfg_data;
            end
            lowest_reg       <= lowest_next;
            wrap_reg         <= wrap_next;
            best_found_reg   <= best_found_next;
            tr_v_reg         <= tr_v_next;
            tr_first_reg     <= tr_first_next;
            tr_last_reg      <= tr_last_next;
            close_reg        <= close_next;
            dr_v_reg         <= dr_v_next;
            dr_last_reg      <= dr_last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        m_reg         <= m_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        prev_reg      <= prev_next;
        pv_reg        <= pv_next;
        vp_reg        <= vp_next;
        best_reg      <= best_next;
        bpos_reg      <= bpos_next;
        idx_reg       <= idx_next;
        first_reg     <= first_next;
        acc_reg       <= acc_next;
        tour_cost_reg <= tour_cost_next;
        best_cost_reg <= best_cost_next;
        last_perm_reg <= last_perm_next;
    end

    assign result_valid     = result_valid_reg;
    assign tour_cost        = tour_cost_reg;
    assign best_cost        = best_cost_reg;
    assign last_permutation = last_perm_reg;

endmodule

// ===== verif/tsp_permutation_tour_evaluator_core_checker.sv =====
// checker for the tour evaluator: predicts each tour score and compares the result transactions
`timescale 1ns / 1ps
module tsp_permutation_tour_evaluator_core_checker
    import tspe_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [CITY_W-1:0] from_city,
    input  logic [CITY_W-1:0] to_city,
    input  logic [DIST_W-1:0] distance,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [COST_W-1:0] tour_cost,
    input  logic [COST_W-1:0] best_cost,
    input  logic              last_permutation,
    output int                fail_count,
    output int                scores_outstanding
);

    typedef struct packed {
        logic [COST_W-1:0] tour_cost;
        logic [COST_W-1:0] best_cost;
        logic              last_permutation;
    } tour_score_t;

    localparam logic [DIST_W-1:0] DIST_KEEP =
        (DIST_BITS >= DIST_W) ? {DIST_W{1'b1}} : DIST_W'((64'd1 << DIST_BITS) - 64'd1);

    logic [CITY_W-1:0] tour_seq [MAX_CITIES];
    logic [DIST_W-1:0] dist_matrix [MAX_CITIES][MAX_CITIES];
    logic [COST_W-1:0] lowest_seen;
    logic [CNT_W-1:0]  city_setting;
    tour_score_t       expected_scores [$];

    function automatic int cities_in_use();
        int n;
        n = int'(city_setting);
        if (n < MIN_CITIES)
            n = MIN_CITIES;
        if (n > MAX_CITIES)
            n = MAX_CITIES;
        return n;
    endfunction

    task automatic restore_identity();
        int i;
        for (i = 0; i < MAX_CITIES; i++)
        begin
            tour_seq[i] = CITY_W'(i);
        end
    endtask

    function automatic logic [COST_W-1:0] closed_tour_cost();
        int n;
        int i;
        int a;
        int b;
        logic [COST_W:0] sum;
        n = cities_in_use();
        sum = '0;
        for (i = 0; i < n; i++)
        begin
            a = int'(tour_seq[i]) % MAX_CITIES;
            b = int'(tour_seq[(i + 1 == n) ? 0 : i + 1]) % MAX_CITIES;
            sum = sum + dist_matrix[a][b];
            if (sum > COST_MAX)
                sum = COST_MAX;
        end
        return sum[COST_W-1:0];
    endfunction

    // next lexicographic order of positions 1..n-1, identity after the last one
    task automatic advance_tail(output logic wrapped);
        int n;
        int m;
        int k;
        int p;
        int q;
        logic [CITY_W-1:0] tmp;
        n = cities_in_use();
        m = n - 2;
        wrapped = 1'b0;
        while (m > 0 && tour_seq[m] > tour_seq[m + 1])
            m--;
        if (m == 0)
        begin
            restore_identity();
            wrapped = 1'b1;
        end
        else
        begin
            k = n - 1;
            while (k > m && tour_seq[m] > tour_seq[k])
                k--;
            tmp = tour_seq[m];
            tour_seq[m] = tour_seq[k];
            tour_seq[k] = tmp;
            p = m + 1;
            q = n - 1;
            while (p < q)
            begin
                tmp = tour_seq[p];
                tour_seq[p] = tour_seq[q];
                tour_seq[q] = tmp;
                p++;
                q--;
            end
        end
    endtask

    task automatic take_item();
        tour_score_t score;
        logic wrapped;
        wrapped = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                if (from_city < MAX_CITIES && to_city < MAX_CITIES)
                    dist_matrix[from_city][to_city] = distance & DIST_KEEP;
            end
            CMD_RESTART, CMD_STEP:
            begin
                if (cmd == CMD_RESTART)
                begin
                    restore_identity();
                    lowest_seen = COST_MAX;
                end
                else
                begin
                    advance_tail(wrapped);
                end
                score.tour_cost = closed_tour_cost();
                if (score.tour_cost < lowest_seen)
                    lowest_seen = score.tour_cost;
                score.best_cost = lowest_seen;
                score.last_permutation = wrapped;
                expected_scores.push_back(score);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_score();
        tour_score_t want;
        if (expected_scores.size() == 0)
        begin
            $error("result transaction with nothing expected: tour_cost %0h best_cost %0h",
                   tour_cost, best_cost);
            fail_count++;
        end
        else
        begin
            want = expected_scores.pop_front();
            if (tour_cost !== want.tour_cost)
            begin
                $error("tour_cost: expected %0h, actual %0h", want.tour_cost, tour_cost);
                fail_count++;
            end
            if (best_cost !== want.best_cost)
            begin
                $error("best_cost: expected %0h, actual %0h", want.best_cost, best_cost);
                fail_count++;
            end
            if (last_permutation !== want.last_permutation)
            begin
                $error("last_permutation: expected %0b, actual %0b",
                       want.last_permutation, last_permutation);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_identity();
            lowest_seen = COST_MAX;
            city_setting = NUM_CITIES_RESET;
            expected_scores.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                city_setting = cfg_data;
            if (item_valid && !item_stall)
                take_item();
            if (result_valid && !result_stall)
                check_score();
        end
        scores_outstanding = expected_scores.size();
    end

endmodule

// ===== verif/tsp_permutation_tour_evaluator_core_tb.sv =====
// testbench top for the tour evaluator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tsp_permutation_tour_evaluator_core_tb;
    import tspe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 96;
    localparam int PRESSURE_PHASE = 9;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int DRAIN_GUARD    = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [CMD_W-1:0]  cmd = CMD_LOAD;
    logic [CITY_W-1:0] from_city = '0;
    logic [CITY_W-1:0] to_city = '0;
    logic [DIST_W-1:0] distance = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [COST_W-1:0] tour_cost;
    logic [COST_W-1:0] best_cost;
    logic              last_permutation;

    int fail_count;
    int scores_outstanding;
    int idle_pct = 21;
    int stall_pct = 79;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    logic [CNT_W-1:0] phase_counts [PHASES];

    always #10 clk = ~clk;

    tsp_permutation_tour_evaluator_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .cmd              (cmd),
        .from_city        (from_city),
        .to_city          (to_city),
        .distance         (distance),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .tour_cost        (tour_cost),
        .best_cost        (best_cost),
        .last_permutation (last_permutation)
    );

    tsp_permutation_tour_evaluator_core_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_data           (cfg_data),
        .item_valid         (item_valid),
        .item_stall         (item_stall),
        .cmd                (cmd),
        .from_city          (from_city),
        .to_city            (to_city),
        .distance           (distance),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .tour_cost          (tour_cost),
        .best_cost          (best_cost),
        .last_permutation   (last_permutation),
        .fail_count         (fail_count),
        .scores_outstanding (scores_outstanding)
    );

    // receiver side, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [DIST_W-1:0] random_distance();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return DIST_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [CITY_W-1:0] f,
                             input logic [CITY_W-1:0] t, input logic [DIST_W-1:0] d);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        cmd <= c;
        from_city <= f;
        to_city <= t;
        distance <= d;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // wait until every score has come back, then let a load or unused command finish
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge clk);
        item_valid <= 1'b0;
        while (scores_outstanding != 0 && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_city_count(input logic [CNT_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int p;
        int i;
        int f;
        int t;
        int r;
        phase_counts = '{5'd4, 5'd5, 5'd0, 5'd6, 5'd3, 5'd1,
                         5'd16, 5'd7, 5'd31, 5'd4, 5'd5, 5'd17};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // whole matrix first so no tour ever reads an unloaded entry
        write_city_count(5'd16);
        for (f = 0; f < MAX_CITIES_DEF; f++)
        begin
            for (t = 0; t < MAX_CITIES_DEF; t++)
            begin
                send_item(CMD_LOAD, CITY_W'(f), CITY_W'(t), random_distance());
            end
        end

        send_item(CMD_LOAD, 4'd0, 4'd1, '0);
        send_item(CMD_LOAD, 4'd1, 4'd2, '1);
        send_item(CMD_RESTART, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_STEP, 4'hF, 4'hF, '1);
        send_item(CMD_UNUSED, 4'hF, 4'hF, '1);
        write_city_count(5'd3);
        send_item(CMD_RESTART, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_RESTART, '0, '0, '0);
        write_city_count(5'd2);
        send_item(CMD_RESTART, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_STEP, '0, '0, '0);
        // city count raised without a restart
        write_city_count(5'd31);
        send_item(CMD_STEP, '0, '0, '0);
        send_item(CMD_RESTART, '0, '0, '0);

        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES / 3)
            begin
                idle_pct = 79;
                stall_pct = 21;
            end
            if (p == 2 * PHASES / 3)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            write_city_count(phase_counts[p]);
            if (p == PRESSURE_PHASE)
                hold_request <= 1'b1;
            if ($urandom_range(3) != 0)
                send_item(CMD_RESTART, CITY_W'($urandom), CITY_W'($urandom), DIST_W'($urandom));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(99);
                if (r < 75)
                    send_item(CMD_STEP, CITY_W'($urandom), CITY_W'($urandom), DIST_W'($urandom));
                else if (r < 78)
                    send_item(CMD_RESTART, CITY_W'($urandom), CITY_W'($urandom),
                              DIST_W'($urandom));
                else if (r < 96)
                    send_item(CMD_LOAD, CITY_W'($urandom), CITY_W'($urandom), random_distance());
                else
                    send_item(CMD_UNUSED, CITY_W'($urandom), CITY_W'($urandom),
                              DIST_W'($urandom));
            end
        end

        settle();
        if (fail_count == 0 && scores_outstanding == 0)
            $display("tsp_permutation_tour_evaluator_core_tb: clean");
        else
            $display("tsp_permutation_tour_evaluator_core_tb: errors");
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("tsp_permutation_tour_evaluator_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tspe_pkg.sv
src/tspe_tour_mem.sv
src/tspe_dist_mem.sv
src/tsp_permutation_tour_evaluator_core.sv
verif/tsp_permutation_tour_evaluator_core_checker.sv
verif/tsp_permutation_tour_evaluator_core_tb.sv
